// ----- hdl/msp_chk_pkg.sv -----
// Shared types and constants for the response-frame checker.
package msp_chk_pkg;

	localparam int HEADER_LEN = 3;
	localparam int BYTE_W     = 8;
	localparam int POS_W      = 9;
	localparam int TDATA_W    = 16;
	localparam int PAD_W      = TDATA_W - BYTE_W - 2;

	localparam logic [POS_W-1:0] POS_SIZE = POS_W'(HEADER_LEN);
	localparam logic [POS_W-1:0] POS_CMD  = POS_W'(HEADER_LEN + 1);
	localparam logic [POS_W-1:0] POS_DATA = POS_W'(HEADER_LEN + 2);

	typedef enum logic [0:0] {
		REG_CMD = 1'b0,
		REG_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_LEN = 2'd1,
		ST_CMD = 2'd2,
		ST_SUM = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] payload;
		status_t           status;
		logic              last;
	} result_t;

endpackage

// ----- hdl/msp_chk_inreg.sv -----
// Input register stage for received bytes.
module msp_chk_inreg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [msp_chk_pkg::BYTE_W-1:0]    s_tdata,
	input  logic                              s_tuser,
	input  logic                              advance,
	output logic                              valid_s1,
	output logic [msp_chk_pkg::BYTE_W-1:0]    byte_s1,
	output logic                              start_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

endmodule

// ----- hdl/msp_chk_core.sv -----
// Frame position tracking, checksum and header checks.
module msp_chk_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [msp_chk_pkg::BYTE_W-1:0]    byte_s1,
	input  logic                              start_s1,
	input  logic [msp_chk_pkg::BYTE_W-1:0]    exp_cmd,
	input  logic [msp_chk_pkg::BYTE_W-1:0]    exp_len,
	output msp_chk_pkg::result_t              res
);

	logic [msp_chk_pkg::POS_W-1:0]  pos_q, pos_n, pos_eff, pos_sum;
	logic [msp_chk_pkg::BYTE_W-1:0] xor_q, xor_n, xor_eff;
	logic                           len_bad_q, len_bad_n, len_bad_eff;
	logic                           cmd_bad_q, cmd_bad_n, cmd_bad_eff;

	assign pos_eff     = start_s1 ? '0 : pos_q;
	assign xor_eff     = start_s1 ? '0 : xor_q;
	assign len_bad_eff = start_s1 ? 1'b0 : len_bad_q;
	assign cmd_bad_eff = start_s1 ? 1'b0 : cmd_bad_q;
	assign pos_sum     = msp_chk_pkg::POS_DATA + {1'b0, exp_len};

	always_comb begin
		pos_n       = pos_eff + 1'b1;
		xor_n       = xor_eff;
		len_bad_n   = len_bad_eff;
		cmd_bad_n   = cmd_bad_eff;
		res.valid   = 1'b0;
		res.kind    = msp_chk_pkg::KIND_PAYLOAD;
		res.payload = '0;
		res.status  = msp_chk_pkg::ST_OK;
		res.last    = 1'b0;
		priority if (pos_eff >= pos_sum) begin
			pos_n     = '0;
			xor_n     = '0;
			len_bad_n = 1'b0;
			cmd_bad_n = 1'b0;
			res.valid = 1'b1;
			res.kind  = msp_chk_pkg::KIND_STATUS;
			res.last  = 1'b1;
			priority if (len_bad_eff) begin
				res.status = msp_chk_pkg::ST_LEN;
			end else if (cmd_bad_eff) begin
				res.status = msp_chk_pkg::ST_CMD;
			end else if (xor_eff != byte_s1) begin
				res.status = msp_chk_pkg::ST_SUM;
			end else begin
				res.status = msp_chk_pkg::ST_OK;
			end
		end else if (pos_eff < msp_chk_pkg::POS_SIZE) begin
			// skip preamble
		end else if (pos_eff == msp_chk_pkg::POS_SIZE) begin
			len_bad_n = (byte_s1 != exp_len);
			xor_n     = byte_s1;
		end else if (pos_eff == msp_chk_pkg::POS_CMD) begin
			cmd_bad_n = (byte_s1 != exp_cmd);
			xor_n     = xor_eff ^ byte_s1;
		end else begin
			xor_n       = xor_eff ^ byte_s1;
			res.valid   = 1'b1;
			res.payload = byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			xor_q     <= '0;
			len_bad_q <= 1'b0;
			cmd_bad_q <= 1'b0;
		end else if (advance) begin
			pos_q     <= pos_n;
			xor_q     <= xor_n;
			len_bad_q <= len_bad_n;
			cmd_bad_q <= cmd_bad_n;
		end
	end

endmodule

// ----- hdl/msp_response_checker.sv -----
// Top level of the response-frame checker.
// Usage:
//   Slave side takes one received byte per request: s_tdata holds the byte,
//   s_tuser marks the byte as frame byte zero. The frame is a preamble of
//   HEADER_LEN bytes, a size byte, a command byte, expected_length payload
//   bytes and an XOR checksum byte.
//   Master side gives one result per payload byte (m_tuser low, byte in
//   m_tdata[7:0]) and one status after the checksum byte (m_tuser high,
//   status in m_tdata[9:8], m_tlast high). Preamble, size and command
//   bytes give no result.
//   Requests pass the single input and output register pair around the
//   check logic; one request is taken every cycle, unless a result waits
//   for a stalled receiver.
//   Write expected_command and expected_length through cfg_we while idle.
//   Reset clears both registers, the frame position, checksum and flags.
//   When the receiver stalls, the result holds; the input register still
//   drains requests that give no result, and further requests wait.
module msp_response_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [msp_chk_pkg::BYTE_W-1:0]      s_tdata,  // rx_byte
	input  logic                                s_tuser,  // frame_start
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [msp_chk_pkg::TDATA_W-1:0]     m_tdata,  // payload_byte, frame_status
	output logic                                m_tuser,  // result_kind
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [0:0]                          cfg_index,
	input  logic [msp_chk_pkg::BYTE_W-1:0]      cfg_data
);

	logic                           valid_s1, start_s1, advance;
	logic [msp_chk_pkg::BYTE_W-1:0] byte_s1;
	logic [msp_chk_pkg::BYTE_W-1:0] exp_cmd_q, exp_len_q;
	logic [msp_chk_pkg::BYTE_W-1:0] payload_q;
	msp_chk_pkg::status_t           status_q;
	msp_chk_pkg::kind_t             kind_q;
	logic                           last_q, out_valid_q;
	msp_chk_pkg::result_t           res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cmd_q <= '0;
			exp_len_q <= '0;
		end else if (cfg_we) begin
			unique case (msp_chk_pkg::reg_idx_t'(cfg_index))
				msp_chk_pkg::REG_CMD: exp_cmd_q <= cfg_data;
				msp_chk_pkg::REG_LEN: exp_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!out_valid_q || m_tready || !res.valid);

	msp_chk_inreg u_inreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1)
	);

	msp_chk_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.start_s1 (start_s1),
		.exp_cmd  (exp_cmd_q),
		.exp_len  (exp_len_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			payload_q <= res.payload;
			status_q  <= res.status;
			kind_q    <= res.kind;
			last_q    <= res.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{msp_chk_pkg::PAD_W{1'b0}}, status_q, payload_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

// ----- hdl/msp_chk_checker.sv -----
// Port-level assertions for the response-frame checker, bound to the top level.
module msp_chk_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [msp_chk_pkg::TDATA_W-1:0]    m_tdata,
	input logic                               m_tuser,
	input logic                               m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	a_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == msp_chk_pkg::KIND_PAYLOAD) |->
		(m_tdata[9:8] == msp_chk_pkg::ST_OK) && !m_tlast)
		else $error("payload result carries status or last");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == msp_chk_pkg::KIND_STATUS) |->
		(m_tdata[7:0] == 8'd0) && m_tlast)
		else $error("status result carries payload or lacks last");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:10] == 6'd0))
		else $error("padding bits set");

endmodule

bind msp_response_checker msp_chk_checker u_msp_chk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- bench/msp_response_checker_tb.sv -----
// Self-checking bench for the response-frame checker: frames in, results checked.
module msp_response_checker_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	typedef struct {
		msp_chk_pkg::kind_t   kind;
		logic [7:0]           payload;
		msp_chk_pkg::status_t status;
		logic                 last;
	} frame_result_t;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [msp_chk_pkg::BYTE_W-1:0]  s_tdata = '0;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [msp_chk_pkg::TDATA_W-1:0] m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;
	logic                            cfg_we = 1'b0;
	logic [0:0]                      cfg_index = '0;
	logic [msp_chk_pkg::BYTE_W-1:0]  cfg_data = '0;

	msp_response_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rx_item_t      rx_q[$];
	frame_result_t frame_results_q[$];
	rx_item_t      next_item;

	logic [7:0] want_cmd = '0;
	logic [7:0] want_len = '0;
	logic [8:0] frame_pos = '0;
	logic [7:0] frame_xor = '0;
	logic       len_bad = 1'b0;
	logic       cmd_bad = 1'b0;

	int  n_sent = 0;
	int  n_taken = 0;
	int  n_errors = 0;
	int  n_payload_seen = 0;
	int  status_seen[4] = '{0, 0, 0, 0};
	int  n_settings = 0;
	int  cycle_cnt = 0;
	int  s_idle_pct = 0;
	int  r_idle_pct = 0;
	int  hold_left = 0;
	bit  hold_trigger = 0;
	bit  req_taken = 0;
	bit  need_mark = 1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame_state();
		frame_pos = '0;
		frame_xor = '0;
		len_bad = 1'b0;
		cmd_bad = 1'b0;
	endfunction

	function automatic void track_frame_byte(input logic [7:0] b, input logic mark);
		int            sum_pos;
		int            p;
		frame_result_t r;
		sum_pos = msp_chk_pkg::HEADER_LEN + 2 + int'(want_len);
		if (mark)
			clear_frame_state();
		p = int'(frame_pos);
		if (p >= sum_pos) begin
			r.kind = msp_chk_pkg::KIND_STATUS;
			r.payload = '0;
			r.last = 1'b1;
			if (len_bad)
				r.status = msp_chk_pkg::ST_LEN;
			else if (cmd_bad)
				r.status = msp_chk_pkg::ST_CMD;
			else if (frame_xor != b)
				r.status = msp_chk_pkg::ST_SUM;
			else
				r.status = msp_chk_pkg::ST_OK;
			frame_results_q.push_back(r);
			clear_frame_state();
		end else begin
			frame_pos = frame_pos + 9'd1;
			if (p == msp_chk_pkg::HEADER_LEN) begin
				len_bad = (b != want_len);
				frame_xor = b;
			end else if (p == msp_chk_pkg::HEADER_LEN + 1) begin
				cmd_bad = (b != want_cmd);
				frame_xor = frame_xor ^ b;
			end else if (p > msp_chk_pkg::HEADER_LEN + 1) begin
				frame_xor = frame_xor ^ b;
				r.kind = msp_chk_pkg::KIND_PAYLOAD;
				r.payload = b;
				r.status = msp_chk_pkg::ST_OK;
				r.last = 1'b0;
				frame_results_q.push_back(r);
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		n_errors++;
		$display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycle_cnt);
	endtask

	task automatic check_result();
		frame_result_t r;
		if (frame_results_q.size() == 0) begin
			report_mismatch("result with none pending, kind", int'(m_tuser), -1);
		end else begin
			r = frame_results_q.pop_front();
			if (m_tuser != r.kind)
				report_mismatch("result_kind", int'(m_tuser), int'(r.kind));
			if (m_tdata[7:0] != r.payload)
				report_mismatch("payload_byte", int'(m_tdata[7:0]), int'(r.payload));
			if (m_tdata[9:8] != r.status)
				report_mismatch("frame_status", int'(m_tdata[9:8]), int'(r.status));
			if (m_tlast != r.last)
				report_mismatch("frame_last", int'(m_tlast), int'(r.last));
			if (r.kind == msp_chk_pkg::KIND_STATUS)
				status_seen[int'(r.status)]++;
			else
				n_payload_seen++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			req_taken = s_tvalid && s_tready;
			if (req_taken) begin
				track_frame_byte(s_tdata, s_tuser);
				n_taken++;
			end
			if (m_tvalid && m_tready)
				check_result();
		end else begin
			req_taken = 0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout: %0d requests taken of %0d", n_taken, n_sent);
			$display("[msp_response_checker] ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_taken) begin
			if (rx_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
				next_item = rx_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_item.rx_byte;
				s_tuser <= next_item.frame_start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_trigger) begin
			hold_trigger = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= r_idle_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic mark);
		rx_item_t it;
		it.rx_byte = b;
		it.frame_start = mark;
		rx_q.push_back(it);
		n_sent++;
	endtask

	task automatic queue_frame(input bit mark, input int n_pay, input logic [7:0] size_b,
			input logic [7:0] cmd_b, input logic [7:0] sum_flip);
		logic [7:0] x;
		logic [7:0] d;
		bit         m;
		m = mark;
		for (int i = 0; i < msp_chk_pkg::HEADER_LEN; i++) begin
			push_byte(8'($urandom), m);
			m = 0;
		end
		push_byte(size_b, m);
		push_byte(cmd_b, 1'b0);
		x = size_b ^ cmd_b;
		for (int i = 0; i < n_pay; i++) begin
			d = 8'($urandom);
			push_byte(d, 1'b0);
			x = x ^ d;
		end
		push_byte(x ^ sum_flip, 1'b0);
	endtask

	task automatic write_reg(input msp_chk_pkg::reg_idx_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == msp_chk_pkg::REG_CMD)
			want_cmd = val;
		else
			want_len = val;
	endtask

	task automatic wait_idle(input int extra);
		while (n_taken != n_sent || frame_results_q.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic queue_random_sequence();
		int         roll;
		logic [7:0] size_b;
		logic [7:0] cmd_b;
		logic [7:0] flip;
		roll = $urandom_range(0, 99);
		if (roll < 75) begin
			size_b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : want_len;
			cmd_b = ($urandom_range(0, 9) == 0) ? 8'($urandom) : want_cmd;
			flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
			queue_frame(need_mark || $urandom_range(0, 1), int'(want_len), size_b, cmd_b, flip);
			need_mark = 0;
		end else if (roll < 90) begin
			queue_frame($urandom_range(0, 1), $urandom_range(0, int'(want_len) + 3),
				8'($urandom), 8'($urandom), 8'h00);
			need_mark = 1;
		end else begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(0, 9) == 0);
			need_mark = 1;
		end
	endtask

	initial begin
		int s;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		s_idle_pct = 34;
		r_idle_pct = 71;
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		queue_frame(1, 0, 8'h00, 8'h00, 8'h00);
		queue_frame(0, 0, 8'hFF, 8'h00, 8'h00);
		wait_idle(8);
		write_reg(msp_chk_pkg::REG_CMD, 8'hFF);
		write_reg(msp_chk_pkg::REG_LEN, 8'h01);
		n_settings++;
		queue_frame(1, 1, 8'h01, 8'h00, 8'h00);
		queue_frame(0, 1, 8'h01, 8'hFF, 8'h5A);
		wait_idle(8);

		for (int mode = 0; mode < 3; mode++) begin
			s_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 71 : 0;
			r_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 34 : 0;
			for (int k = 0; k < 3; k++) begin
				s = mode * 3 + k;
				wait_idle(8);
				if (s == 0) begin
					write_reg(msp_chk_pkg::REG_CMD, 8'h00);
					write_reg(msp_chk_pkg::REG_LEN, 8'h00);
				end else if (s == 4) begin
					write_reg(msp_chk_pkg::REG_CMD, 8'hFF);
					write_reg(msp_chk_pkg::REG_LEN, 8'hFF);
				end else begin
					write_reg(msp_chk_pkg::REG_CMD, 8'($urandom));
					write_reg(msp_chk_pkg::REG_LEN,
						(s == 7) ? 8'hFF : 8'($urandom_range(1, 8)));
				end
				n_settings++;
				need_mark = 1;
				if (s == 1)
					hold_trigger = 1;
				while (n_sent < (s + 1) * 100)
					queue_random_sequence();
			end
		end

		wait_idle(10);
		$display("run: %0d requests over %0d register settings, %0d payload results",
			n_sent, n_settings, n_payload_seen);
		$display("statuses seen ok/len/cmd/sum: %0d/%0d/%0d/%0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (n_errors == 0 && frame_results_q.size() == 0)
			$display("[msp_response_checker] OK");
		else
			$display("[msp_response_checker] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/msp_chk_pkg.sv
hdl/msp_chk_inreg.sv
hdl/msp_chk_core.sv
hdl/msp_response_checker.sv
hdl/msp_chk_checker.sv
bench/msp_response_checker_tb.sv
